// ===== design/bapsm_pkg.sv =====
package bapsm_pkg;

  localparam int MAX_BINS    = 2048;
  localparam int MAX_BATCHES = 64;

  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int BATCH_W    = $clog2(MAX_BATCHES);
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + BATCH_W;
  localparam int NORM_W     = 24;
  localparam int BCNT_W     = 7;
  localparam int BINS_W     = 12;
  localparam int SDIV_W     = 11;
  localparam int X_W        = 18;
  localparam int Y_W        = 24;
  localparam int PROD_W     = SUM_W + NORM_W;
  localparam int FRAC_DROP  = 8;
  localparam int AMP_W      = PROD_W - FRAC_DROP + 1;
  localparam int AVG_EXT_W  = AMP_W + 1;
  localparam int DIV_W      = AMP_W - 1;
  localparam int DIVR_W     = 11;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int X_SHIFT    = 17;
  localparam int Q16_ONE    = 65536;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [NORM_W-1:0] NORM_RESET    = NORM_W'(65536);
  localparam logic [BCNT_W-1:0] BATCHES_RESET = BCNT_W'(1);
  localparam logic [BINS_W-1:0] BINS_RESET    = BINS_W'(MAX_BINS);
  localparam logic [SDIV_W-1:0] SMOOTH_RESET  = SDIV_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM    = 8'd0,
    REG_BATCHES = 8'd1,
    REG_BINS    = 8'd2,
    REG_SMOOTH  = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NORM_W-1:0]  norm;
    logic [BIN_W-1:0]   bins_m1;
    logic [BATCH_W-1:0] last_batch;
    logic [DIVR_W-1:0]  divisor;
    logic               geo_wr;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]           bin;
    logic                       first;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== design/bapsm_if.sv =====
interface bapsm_in_if;
  import bapsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bapsm_out_if;
  import bapsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BIN_W-1:0]      bin_index;
  logic signed [X_W-1:0] plot_x;
  logic signed [Y_W-1:0] plot_y;
  modport source (output valid, output bin_index, output plot_x, output plot_y, input ready);
  modport sink   (input valid, input bin_index, input plot_x, input plot_y, output ready);
endinterface

interface bapsm_cfg_if;
  import bapsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bapsm_cfg.sv =====
module bapsm_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  bapsm_cfg_if.sink        cfg_i,
  output bapsm_pkg::cfg_t  cfg_o
);
  import bapsm_pkg::*;

  logic [NORM_W-1:0] norm_q;
  logic [BCNT_W-1:0] batches_q;
  logic [BINS_W-1:0] bins_q;
  logic [SDIV_W-1:0] smooth_q;
  logic              wr;
  logic [BINS_W-1:0] bins_m1_full;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q    <= NORM_RESET;
      batches_q <= BATCHES_RESET;
      bins_q    <= BINS_RESET;
      smooth_q  <= SMOOTH_RESET;
    end else if (wr) begin
      case (cfg_i.index)
        REG_NORM:    norm_q    <= cfg_i.data[NORM_W-1:0];
        REG_BATCHES: batches_q <= cfg_i.data[BCNT_W-1:0];
        REG_BINS:    bins_q    <= cfg_i.data[BINS_W-1:0];
        REG_SMOOTH:  smooth_q  <= cfg_i.data[SDIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign bins_m1_full = bins_q - BINS_W'(1);

  always_comb begin
    cfg_o.norm = norm_q;
    if (bins_q < BINS_W'(2)) begin
      cfg_o.bins_m1 = BIN_W'(1);
    end else if (bins_q > BINS_W'(MAX_BINS)) begin
      cfg_o.bins_m1 = BIN_W'(MAX_BINS - 1);
    end else begin
      cfg_o.bins_m1 = bins_m1_full[BIN_W-1:0];
    end
    if (batches_q == '0) begin
      cfg_o.last_batch = '0;
    end else if (batches_q > BCNT_W'(MAX_BATCHES)) begin
      cfg_o.last_batch = BATCH_W'(MAX_BATCHES - 1);
    end else begin
      cfg_o.last_batch = BATCH_W'(batches_q - BCNT_W'(1));
    end
    cfg_o.divisor = (smooth_q == '0) ? DIVR_W'(1) : DIVR_W'(smooth_q);
    cfg_o.geo_wr  = wr && (cfg_i.index == REG_BATCHES || cfg_i.index == REG_BINS);
  end

endmodule

// ===== design/bapsm_front.sv =====
module bapsm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bapsm_in_if.sink               in_i,
  input  bapsm_pkg::cfg_t        cfg_i,
  input  logic                   clear_done_i,
  input  bapsm_pkg::fifo_stat_t  fifo_stat_i,
  output logic                   push_o,
  output bapsm_pkg::item_t       item_o
);
  import bapsm_pkg::*;

  logic [BIN_W-1:0]   bin_q;
  logic [BATCH_W-1:0] batch_q;

  assign in_i.ready   = clear_done_i && !fifo_stat_i.full;
  assign push_o       = in_i.valid && in_i.ready;
  assign item_o.sample = in_i.sample;
  assign item_o.bin    = bin_q;
  assign item_o.first  = (batch_q == '0);
  assign item_o.last   = (batch_q == cfg_i.last_batch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= '0;
      batch_q <= '0;
    end else if (cfg_i.geo_wr) begin
      bin_q   <= '0;
      batch_q <= '0;
    end else if (push_o) begin
      if (bin_q == cfg_i.bins_m1) begin
        bin_q   <= '0;
        batch_q <= (batch_q == cfg_i.last_batch) ? '0 : batch_q + BATCH_W'(1);
      end else begin
        bin_q <= bin_q + BIN_W'(1);
      end
    end
  end

  a_geo_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.geo_wr |=> (bin_q == '0 && batch_q == '0))
    else $error("position not restarted after geometry write");

endmodule

// ===== design/bapsm_fifo.sv =====
module bapsm_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bapsm_pkg::item_t       item_i,
  input  logic                   pop_i,
  output bapsm_pkg::item_t       item_o,
  output bapsm_pkg::fifo_stat_t  stat_o
);
  import bapsm_pkg::*;

  item_t                 entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FIFO_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

endmodule

// ===== design/bapsm_div.sv =====
module bapsm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bapsm_pkg::DIV_W-1:0]   dividend_i,
  input  logic [bapsm_pkg::DIVR_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [bapsm_pkg::DIV_W-1:0]   quotient_o
);
  import bapsm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVR_W-1:0]    rem_q;
  logic [DIVR_W-1:0]    dvs_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVR_W:0]      rem_sh;
  logic [DIVR_W:0]      rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_W);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

// ===== design/bapsm_back.sv =====
module bapsm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bapsm_pkg::cfg_t        cfg_i,
  input  bapsm_pkg::fifo_stat_t  fifo_stat_i,
  input  bapsm_pkg::item_t       item_i,
  output logic                   pop_o,
  output logic                   clear_done_o,
  bapsm_out_if.source            out_o
);
  import bapsm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ACC, S_MUL, S_AMP, S_DIV_X, S_DIV_A, S_DIV_B, S_OUT
  } state_e;

  state_e                      state_q;
  item_t                       item_q;
  logic [BIN_W-1:0]            clr_q;
  logic signed [SUM_W-1:0]     sum_mem [MAX_BINS];
  logic signed [Y_W-1:0]       avg_mem [MAX_BINS];
  logic signed [SUM_W-1:0]     sum_rd_q;
  logic signed [Y_W-1:0]       avg_rd_q;
  logic signed [SUM_W-1:0]     sum_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [AMP_W-1:0]     amp_q;
  logic signed [AMP_W-1:0]     qa_q;
  logic signed [X_W-1:0]       x_q;
  logic                        out_valid_q;
  logic [BIN_W-1:0]            out_bin_q;
  logic signed [X_W-1:0]       out_x_q;
  logic signed [Y_W-1:0]       out_y_q;

  logic signed [SUM_W-1:0]     sum_d;
  logic signed [PROD_W:0]      prod_full;
  logic signed [AMP_W-1:0]     amp_d;
  logic [Y_W-1:0]              avg_mag;
  logic [AMP_W-1:0]            amp_neg;
  logic [DIV_W-1:0]            amp_mag;
  logic signed [AMP_W-1:0]     quo_signed;
  logic signed [AMP_W-1:0]     qb;
  logic signed [AVG_EXT_W-1:0] avg_new;
  logic signed [Y_W-1:0]       y_sat;
  logic                        div_start;
  logic [DIV_W-1:0]            div_dividend;
  logic [DIVR_W-1:0]           div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            div_quo;
  logic                        out_free;
  logic                        fire;
  logic                        sum_we;
  logic                        avg_we;
  logic [BIN_W-1:0]            avg_waddr;
  logic signed [Y_W-1:0]       avg_wdata;

  bapsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = (state_q == S_OUT) && out_free;
  assign pop_o    = (state_q == S_IDLE) && !fifo_stat_i.empty;
  assign clear_done_o = (state_q != S_CLEAR);

  assign out_o.valid     = out_valid_q;
  assign out_o.bin_index = out_bin_q;
  assign out_o.plot_x    = out_x_q;
  assign out_o.plot_y    = out_y_q;

  assign sum_d     = item_q.first ? SUM_W'(item_q.sample) : sum_rd_q + SUM_W'(item_q.sample);
  assign prod_full = sum_q * $signed({1'b0, cfg_i.norm});
  assign amp_d     = AMP_W'($signed(prod_q[PROD_W-1:FRAC_DROP])) - AMP_W'(Q16_ONE);
  assign avg_mag   = avg_rd_q[Y_W-1] ? Y_W'(-avg_rd_q) : Y_W'(avg_rd_q);
  assign amp_neg   = -amp_q;
  assign amp_mag   = amp_q[AMP_W-1] ? amp_neg[DIV_W-1:0] : amp_q[DIV_W-1:0];
  assign quo_signed = $signed({1'b0, div_quo});
  assign qb        = amp_q[AMP_W-1] ? -quo_signed : quo_signed;
  assign avg_new   = AVG_EXT_W'(avg_rd_q) - AVG_EXT_W'(qa_q) + AVG_EXT_W'(qb);

  always_comb begin
    if (avg_new[AVG_EXT_W-1:Y_W-1] == '0 || avg_new[AVG_EXT_W-1:Y_W-1] == '1) begin
      y_sat = avg_new[Y_W-1:0];
    end else if (avg_new[AVG_EXT_W-1]) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cfg_i.divisor;
    case (state_q)
      S_AMP: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(item_q.bin) << X_SHIFT;
        div_divisor  = DIVR_W'(cfg_i.bins_m1);
      end
      S_DIV_X: begin
        div_start    = div_done;
        div_dividend = DIV_W'(avg_mag);
      end
      S_DIV_A: begin
        div_start    = div_done;
        div_dividend = amp_mag;
      end
      default: ;
    endcase
  end

  assign sum_we    = (state_q == S_ACC);
  assign avg_we    = (state_q == S_CLEAR) || fire;
  assign avg_waddr = (state_q == S_CLEAR) ? clr_q : item_q.bin;
  assign avg_wdata = (state_q == S_CLEAR) ? '0 : y_sat;

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[item_q.bin] <= sum_d;
    end
    if (avg_we) begin
      avg_mem[avg_waddr] <= avg_wdata;
    end
    sum_rd_q <= sum_mem[item_q.bin];
    avg_rd_q <= avg_mem[item_q.bin];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      item_q      <= '0;
      sum_q       <= '0;
      prod_q      <= '0;
      amp_q       <= '0;
      qa_q        <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
      out_bin_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + BIN_W'(1);
          if (clr_q == BIN_W'(MAX_BINS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            item_q  <= item_i;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_ACC;
        S_ACC: begin
          sum_q   <= sum_d;
          state_q <= item_q.last ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          prod_q  <= prod_full[PROD_W-1:0];
          state_q <= S_AMP;
        end
        S_AMP: begin
          amp_q   <= amp_d;
          state_q <= S_DIV_X;
        end
        S_DIV_X: begin
          if (div_done) begin
            x_q     <= div_quo[X_W-1:0] - X_W'(Q16_ONE);
            state_q <= S_DIV_A;
          end
        end
        S_DIV_A: begin
          if (div_done) begin
            qa_q    <= avg_rd_q[Y_W-1] ? -quo_signed : quo_signed;
            state_q <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (fire) begin
            out_bin_q   <= item_q.bin;
            out_x_q     <= x_q;
            out_y_q     <= y_sat;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_from_fsm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("queue popped during clearing pass");

endmodule

// ===== design/batch_average_plot_smoother.sv =====
// Flow: a sample that is not in the last batch passes the back end through S_READ and S_ACC.
// A last-batch sample's point turns valid, when the back end is idle, after the states
// S_READ, S_ACC, S_MUL and S_AMP, three passes of the shared one-bit-per-cycle divider
// (38-step divisions: x, avg/d, amp/d) and S_OUT, plus any output stall.
// The back end finishes each sample, and in the last batch its point, before it pops the next one.
// Reset: registers take reset values; a clearing pass over all bins then zeroes the averages while
// no sample is accepted (configuration writes are taken throughout).
module batch_average_plot_smoother (
  input  logic         clk_i,
  input  logic         rst_ni,
  bapsm_in_if.sink     in_i,
  bapsm_out_if.source  out_o,
  bapsm_cfg_if.sink    cfg_i
);
  import bapsm_pkg::*;

  cfg_t       cfg;
  fifo_stat_t fifo_stat;
  item_t      push_item;
  item_t      head_item;
  logic       push;
  logic       pop;
  logic       clear_done;

  bapsm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bapsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg),
    .clear_done_i (clear_done),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .item_o       (push_item)
  );

  bapsm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (fifo_stat)
  );

  bapsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fifo_stat_i  (fifo_stat),
    .item_i       (head_item),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .out_o        (out_o)
  );

endmodule
